// ===== sv/pza_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pza_pkg - shared definitions for the point zone assigner
// Operation and status codes, field widths, parameter defaults and the
// status group returned by the edge crossing unit.
// ----------------------------------------------------------------------------
package pza_pkg;

	// parameter defaults
	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_MAX_ZONES    = 64;
	localparam int DEF_COORD_BITS   = 32;

	// fixed field widths on the ports
	localparam int IN_COORD_W = 32;
	localparam int OP_W       = 2;
	localparam int ZONE_W     = 7;
	localparam int CNT_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int OUT_DATA_W = 40;

	// operation codes (slave tuser)
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	// status codes (master tuser)
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOZONE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OPEN   = 3'd4;

	// smallest ring that is kept
	localparam int MIN_RING = 3;

	// zone value for no match
	localparam logic [ZONE_W-1:0] ZONE_NONE = 7'h7F;

	// edge unit status back to the sequencer
	typedef struct packed {
		logic done;
		logic hit;
	} edge_stat_t;

endpackage

`default_nettype wire

// ===== sv/pza_vertex_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pza_vertex_store - vertex coordinate memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pza_vertex_store #(
	parameter int DEPTH      = 1024,
	parameter int COORD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire logic signed [COORD_BITS-1:0] wr_x,
	input  wire logic signed [COORD_BITS-1:0] wr_y,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic signed [COORD_BITS-1:0]      rd_x,
	output logic signed [COORD_BITS-1:0]      rd_y
);

	logic signed [COORD_BITS-1:0] x_mem [DEPTH];
	logic signed [COORD_BITS-1:0] y_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[wr_addr] <= wr_x;
			y_mem[wr_addr] <= wr_y;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_x <= x_mem[rd_addr];
		rd_y <= y_mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== sv/pza_edge_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pza_edge_unit - even-odd crossing test for one ring edge
// Checks whether edge (i, j) straddles the point's y and, if so, whether the
// point lies left of the edge, by comparing two exact signed products made
// one after the other on a single shared multiplier.
// ----------------------------------------------------------------------------
module pza_edge_unit #(
	parameter int COORD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [COORD_BITS-1:0] px,
	input  wire logic signed [COORD_BITS-1:0] py,
	input  wire logic signed [COORD_BITS-1:0] xi,
	input  wire logic signed [COORD_BITS-1:0] yi,
	input  wire logic signed [COORD_BITS-1:0] xj,
	input  wire logic signed [COORD_BITS-1:0] yj,
	output pza_pkg::edge_stat_t               stat
);
	import pza_pkg::*;

	localparam int MW = COORD_BITS + 1;
	localparam int PW = 2 * MW;

	localparam logic [1:0] STEP_IDLE = 2'd0;
	localparam logic [1:0] STEP_MUL1 = 2'd1;
	localparam logic [1:0] STEP_MUL2 = 2'd2;
	localparam logic [1:0] STEP_CMP  = 2'd3;

	logic [1:0]           step_q;
	logic                 cross_q;
	logic signed [MW-1:0] a_q, b_q, c_q, d_q;
	logic signed [PW-1:0] p1_q, p2_q;

	logic signed [MW-1:0] dy, dpx, dxji, dpy;
	logic                 straddle;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;

	// edge differences, all exact in COORD_BITS+1 bits
	always_comb begin
		dy       = $signed({yj[COORD_BITS-1], yj}) - $signed({yi[COORD_BITS-1], yi});
		dpx      = $signed({px[COORD_BITS-1], px}) - $signed({xi[COORD_BITS-1], xi});
		dxji     = $signed({xj[COORD_BITS-1], xj}) - $signed({xi[COORD_BITS-1], xi});
		dpy      = $signed({py[COORD_BITS-1], py}) - $signed({yi[COORD_BITS-1], yi});
		straddle = (yi > py) != (yj > py);
	end

	// shared multiplier: first (px-xi)*|dy|, then (xj-xi)*(py-yi)*sign(dy)
	always_comb begin
		mul_a = (step_q == STEP_MUL1) ? a_q : c_q;
		mul_b = (step_q == STEP_MUL1) ? b_q : d_q;
		prod  = PW'(mul_a) * PW'(mul_b);
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_IDLE;
			cross_q <= 1'b0;
		end else begin
			case (step_q)
				STEP_IDLE: begin
					if (start) begin
						cross_q <= straddle;
						step_q  <= straddle ? STEP_MUL1 : STEP_CMP;
					end
				end
				STEP_MUL1: step_q <= STEP_MUL2;
				STEP_MUL2: step_q <= STEP_CMP;
				STEP_CMP:  step_q <= STEP_IDLE;
				default:   step_q <= STEP_IDLE;
			endcase
		end
	end

	// operand and product registers
	always_ff @(posedge clk) begin
		if (start && (step_q == STEP_IDLE)) begin
			a_q <= dpx;
			c_q <= dxji;
			// straddle implies dy is nonzero, so the sign bit decides
			if (!dy[MW-1]) begin
				b_q <= dy;
				d_q <= dpy;
			end else begin
				b_q <= -dy;
				d_q <= -dpy;
			end
		end
		if (step_q == STEP_MUL1)
			p1_q <= prod;
		if (step_q == STEP_MUL2)
			p2_q <= prod;
	end

	// compare stage
	always_comb begin
		stat.done = (step_q == STEP_CMP);
		stat.hit  = cross_q && (p1_q < p2_q);
	end

endmodule

`default_nettype wire

// ===== sv/point_zone_assigner_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// point_zone_assigner_unit - point-in-polygon zone lookup
// Loads polygon rings vertex by vertex and answers query points with the
// first ring, in load order, that holds the point by the even-odd rule.
//
//   channel  dir  content
//   s_*      in   tuser operation, tdata {coord_y, coord_x}, tlast last_flag
//   m_*      out  tdata {pad, matched_total, zone}, tuser status
//
// Clear, load and no-op items, and a query with no zones loaded, finish at
// acceptance. A query walks the rings in load order, edge by edge; an edge
// that straddles the point's y takes longer than one that misses it: the
// edge unit has one shared multiplier and the vertex memory one read port.
// No clearing pass after reset. A new item is taken only when the block is
// idle and the result register is empty or being emptied.
// ----------------------------------------------------------------------------
module point_zone_assigner_unit #(
	parameter int MAX_VERTICES = pza_pkg::DEF_MAX_VERTICES,
	parameter int MAX_ZONES    = pza_pkg::DEF_MAX_ZONES,
	parameter int COORD_BITS   = pza_pkg::DEF_COORD_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [2*pza_pkg::IN_COORD_W-1:0]    s_tdata,  // coord_x, coord_y
	input  wire logic [pza_pkg::OP_W-1:0]            s_tuser,  // operation
	input  wire logic                                s_tlast,  // last_flag
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [pza_pkg::OUT_DATA_W-1:0]           m_tdata,  // zone, matched_total, pad
	output logic [pza_pkg::STATUS_W-1:0]             m_tuser   // status
);
	import pza_pkg::*;

	localparam int VT_W = $clog2(MAX_VERTICES + 1);
	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int ZT_W = $clog2(MAX_ZONES + 1);
	localparam int ZA_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ZR   = 3'd1;
	localparam logic [2:0] S_ZW   = 3'd2;
	localparam logic [2:0] S_PRV  = 3'd3;
	localparam logic [2:0] S_VTX  = 3'd4;
	localparam logic [2:0] S_EWT  = 3'd5;

	// control state
	logic [2:0]      state_q;
	logic [VT_W-1:0] vt_q, cvt_q;
	logic [ZT_W-1:0] zt_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ZA_W-1:0] z_q;
	logic            m_tvalid_q;

	// walk and result registers
	logic signed [COORD_BITS-1:0] px_q, py_q, prev_x_q, prev_y_q;
	logic                         last_q, inside_q;
	logic [STATUS_W-1:0]          qstat_q, status_q;
	logic [VT_W-1:0]              start_q, end_q, i_q, rend_q;
	logic [ZONE_W-1:0]            zone_q;
	logic [CNT_W-1:0]             total_q;

	logic [VT_W-1:0] ring_end_mem [MAX_ZONES];

	logic                         accept;
	logic signed [COORD_BITS-1:0] cx, cy;
	logic                         full;
	logic [VT_W-1:0]              nvt, ring_len, i_next, rd_idx;
	logic [ZT_W-1:0]              z_next;
	logic                         last_edge, inside_n;
	logic [CNT_W-1:0]             cnt_inc;
	logic [STATUS_W-1:0]          acc_status;
	logic                         walk_end, res_load;
	logic signed [COORD_BITS-1:0] rd_x, rd_y;
	edge_stat_t                   estat;

	// input decode and next values
	always_comb begin
		s_tready  = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
		accept    = s_tvalid && s_tready;
		cx        = s_tdata[COORD_BITS-1:0];
		cy        = s_tdata[IN_COORD_W+COORD_BITS-1:IN_COORD_W];
		full      = (vt_q == VT_W'(MAX_VERTICES));
		nvt       = vt_q + VT_W'(1);
		ring_len  = nvt - cvt_q;
		i_next    = i_q + VT_W'(1);
		last_edge = (i_next == end_q);
		inside_n  = inside_q ^ estat.hit;
		z_next    = ZT_W'(z_q) + ZT_W'(1);
		cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
	end

	// status of an item finished at acceptance, and result register load
	always_comb begin
		acc_status = ST_OK;
		case (s_tuser)
			OP_LOAD: begin
				if (full)
					acc_status = ST_FULL;
				else if (s_tlast && (ring_len < VT_W'(MIN_RING)))
					acc_status = ST_SHORT;
				else if (s_tlast && (zt_q == ZT_W'(MAX_ZONES)))
					acc_status = ST_FULL;
			end
			OP_QUERY: begin
				if (zt_q == '0)
					acc_status = ST_NOZONE;
			end
			default: acc_status = ST_OK;
		endcase
		walk_end = (state_q == S_EWT) && estat.done && last_edge &&
		           (inside_n || (z_next == zt_q));
		res_load = (accept && !((s_tuser == OP_QUERY) && (zt_q != '0))) || walk_end;
	end

	// vertex read address per sequencer step
	always_comb begin
		case (state_q)
			S_ZW:    rd_idx = rend_q - VT_W'(1);
			S_EWT:   rd_idx = i_next;
			default: rd_idx = i_q;
		endcase
	end

	pza_vertex_store #(
		.DEPTH      (MAX_VERTICES),
		.COORD_BITS (COORD_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && (s_tuser == OP_LOAD) && !full),
		.wr_addr (vt_q[AW-1:0]),
		.wr_x    (cx),
		.wr_y    (cy),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	pza_edge_unit #(
		.COORD_BITS (COORD_BITS)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_VTX),
		.px     (px_q),
		.py     (py_q),
		.xi     (rd_x),
		.yi     (rd_y),
		.xj     (prev_x_q),
		.yj     (prev_y_q),
		.stat   (estat)
	);

	// ring end table: written on ring close, read at the current zone
	always_ff @(posedge clk) begin
		if (accept && (s_tuser == OP_LOAD) && !full && s_tlast &&
		    (ring_len >= VT_W'(MIN_RING)) && (zt_q != ZT_W'(MAX_ZONES)))
			ring_end_mem[zt_q[ZA_W-1:0]] <= nvt;
		rend_q <= ring_end_mem[z_q];
	end

	// sequencer, table totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			vt_q       <= '0;
			cvt_q      <= '0;
			zt_q       <= '0;
			cnt_q      <= '0;
			z_q        <= '0;
			m_tvalid_q <= 1'b0;
			zone_q     <= ZONE_NONE;
			total_q    <= '0;
			status_q   <= ST_OK;
		end else begin
			if (res_load)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						zone_q   <= ZONE_NONE;
						total_q  <= cnt_q;
						status_q <= acc_status;
						case (s_tuser)
							OP_CLEAR: begin
								vt_q  <= '0;
								cvt_q <= '0;
								zt_q  <= '0;
							end
							OP_LOAD: begin
								if (full) begin
									if (s_tlast)
										vt_q <= cvt_q;
								end else if (!s_tlast) begin
									vt_q <= nvt;
								end else if (ring_len < VT_W'(MIN_RING)) begin
									vt_q <= cvt_q;
								end else if (zt_q == ZT_W'(MAX_ZONES)) begin
									vt_q <= cvt_q;
								end else begin
									vt_q  <= nvt;
									cvt_q <= nvt;
									zt_q  <= zt_q + ZT_W'(1);
								end
							end
							OP_QUERY: begin
								if (zt_q == '0) begin
									if (s_tlast)
										cnt_q <= '0;
								end else begin
									z_q     <= '0;
									state_q <= S_ZR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ZR:  state_q <= S_ZW;
				S_ZW:  state_q <= S_PRV;
				S_PRV: state_q <= S_VTX;
				S_VTX: state_q <= S_EWT;
				S_EWT: begin
					if (estat.done) begin
						if (!last_edge) begin
							state_q <= S_VTX;
						end else if (inside_n) begin
							// ring holds the point
							zone_q   <= ZONE_W'(z_q);
							total_q  <= cnt_inc;
							status_q <= qstat_q;
							cnt_q    <= last_q ? '0 : cnt_inc;
							state_q  <= S_IDLE;
						end else if (z_next == zt_q) begin
							// no ring holds the point
							zone_q   <= ZONE_NONE;
							total_q  <= cnt_q;
							status_q <= qstat_q;
							if (last_q)
								cnt_q <= '0;
							state_q  <= S_IDLE;
						end else begin
							z_q     <= z_q + ZA_W'(1);
							state_q <= S_ZR;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= cx;
			py_q    <= cy;
			last_q  <= s_tlast;
			qstat_q <= (vt_q != cvt_q) ? ST_OPEN : ST_OK;
			start_q <= '0;
		end
		case (state_q)
			S_ZW: begin
				end_q    <= rend_q;
				i_q      <= start_q;
				inside_q <= 1'b0;
			end
			S_PRV, S_VTX: begin
				prev_x_q <= rd_x;
				prev_y_q <= rd_y;
			end
			S_EWT: begin
				if (estat.done) begin
					inside_q <= inside_n;
					if (!last_edge)
						i_q <= i_next;
					else
						start_q <= end_q;
				end
			end
			default: begin
			end
		endcase
	end

	// output ports
	always_comb begin
		m_tvalid = m_tvalid_q;
		m_tdata  = {1'b0, total_q, zone_q};
		m_tuser  = status_q;
	end

endmodule

`default_nettype wire

// ===== test/point_zone_assigner_unit_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// point_zone_assigner_unit_test - self-checking bench for the zone assigner
// Drives clear, load, query and no-op items on the input stream and checks
// every item returned against a model of the ring table and the even-odd
// crossing test. It covers directed extremes, a full zone table, a long
// receiver hold-off, and random ring and query traffic, with random idle
// cycles on both streams.
// ----------------------------------------------------------------------------
module point_zone_assigner_unit_test;
	import pza_pkg::*;

	localparam int VERTEX_CAP = DEF_MAX_VERTICES;
	localparam int ZONE_CAP = DEF_MAX_ZONES;
	localparam int CYCLE_LIMIT = 30_000_000;
	localparam int RANDOM_ITEMS = 330;
	localparam longint C_MIN = -64'sh8000_0000;
	localparam longint C_MAX = 64'sh7FFF_FFFF;

	typedef struct packed {
		logic [ZONE_W-1:0]   zone;
		logic [CNT_W-1:0]    matched;
		logic [STATUS_W-1:0] status;
	} zone_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [2*IN_COORD_W-1:0] s_tdata = '0;
	logic [OP_W-1:0] s_tuser = OP_NOP;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	point_zone_assigner_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // coord_x, coord_y
		.s_tuser  (s_tuser),   // operation
		.s_tlast  (s_tlast),   // last_flag
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // zone, matched_total, pad
		.m_tuser  (m_tuser)    // status
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model of the ring table
	longint ring_vx [VERTEX_CAP];
	longint ring_vy [VERTEX_CAP];
	int unsigned ring_end_idx [ZONE_CAP];
	int unsigned stored_vertices = 0;
	int unsigned closed_vertices = 0;
	int unsigned ring_count = 0;
	logic [CNT_W-1:0] batch_matches = '0;

	zone_answer_t pending_answers [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned query_count = 0;
	int unsigned hit_count = 0;
	int unsigned rings_kept = 0;
	int unsigned rings_refused = 0;

	// idle odds in percent, and the remaining receiver hold-off
	int unsigned send_idle_pct = 24;
	int unsigned take_idle_pct = 24;
	int unsigned ready_hold_cycles = 0;

	// bounding boxes of rings loaded since the last clear, to aim queries
	longint box_x [$];
	longint box_y [$];
	longint box_r [$];

	// even-odd test of one ring, exact products instead of a division
	function automatic bit ring_contains(input int unsigned first, input int unsigned stop,
			input longint px, input longint py);
		bit odd_crossings;
		int unsigned i, j;
		logic signed [67:0] ax, bx, cx, dx, dy;
		odd_crossings = 1'b0;
		j = stop - 1;
		for (i = first; i < stop; i++) begin
			if ((ring_vy[i] > py) != (ring_vy[j] > py)) begin
				dy = ring_vy[j] - ring_vy[i];
				ax = px - ring_vx[i];
				cx = ring_vx[j] - ring_vx[i];
				if (dy > 0) begin
					bx = dy;
					dx = py - ring_vy[i];
				end else begin
					bx = -dy;
					dx = ring_vy[i] - py;
				end
				if (ax * bx < cx * dx)
					odd_crossings = !odd_crossings;
			end
			j = i;
		end
		return odd_crossings;
	endfunction

	// apply one accepted item to the model and return the expected answer
	function automatic zone_answer_t predict_zone_answer(input logic [OP_W-1:0] op,
			input logic [31:0] x_raw, input logic [31:0] y_raw, input bit last);
		zone_answer_t ans;
		longint px, py;
		int unsigned z, first;
		bit found;
		px = $signed(x_raw);
		py = $signed(y_raw);
		ans.zone = ZONE_NONE;
		ans.status = ST_OK;
		case (op)
			OP_CLEAR: begin
				stored_vertices = 0;
				closed_vertices = 0;
				ring_count = 0;
			end
			OP_LOAD: begin
				if (stored_vertices >= VERTEX_CAP) begin
					ans.status = ST_FULL;
					if (last)
						stored_vertices = closed_vertices;
				end else begin
					ring_vx[stored_vertices] = px;
					ring_vy[stored_vertices] = py;
					stored_vertices++;
					if (last) begin
						if (stored_vertices - closed_vertices < MIN_RING) begin
							ans.status = ST_SHORT;
							stored_vertices = closed_vertices;
							rings_refused++;
						end else if (ring_count >= ZONE_CAP) begin
							ans.status = ST_FULL;
							stored_vertices = closed_vertices;
							rings_refused++;
						end else begin
							ring_end_idx[ring_count] = stored_vertices;
							ring_count++;
							closed_vertices = stored_vertices;
							rings_kept++;
						end
					end
				end
			end
			OP_QUERY: begin
				query_count++;
				if (ring_count == 0) begin
					ans.status = ST_NOZONE;
				end else begin
					ans.status = (stored_vertices != closed_vertices) ? ST_OPEN : ST_OK;
					first = 0;
					found = 1'b0;
					for (z = 0; z < ring_count && !found; z++) begin
						if (ring_contains(first, ring_end_idx[z], px, py)) begin
							ans.zone = z[ZONE_W-1:0];
							found = 1'b1;
						end
						first = ring_end_idx[z];
					end
					if (found) begin
						hit_count++;
						if (batch_matches != '1)
							batch_matches++;
					end
				end
			end
			default: ;
		endcase
		ans.matched = batch_matches;
		if (op == OP_QUERY && last)
			batch_matches = '0;
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		if (mismatch_count < 40)
			$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
				want);
		mismatch_count++;
	endtask

	// one item out on the input stream; the model runs at acceptance
	task automatic send_item(input logic [OP_W-1:0] op, input longint x, input longint y,
			input bit last);
		zone_answer_t ans;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {y[31:0], x[31:0]};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		ans = predict_zone_answer(op, x[31:0], y[31:0], last);
		pending_answers.push_back(ans);
		items_sent++;
	endtask

	task automatic wait_for_answers();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	function automatic longint rand_offset(input longint r);
		return longint'($urandom_range(0, 32'(2 * r))) - r;
	endfunction

	function automatic longint rand_coord();
		return longint'($signed($urandom()));
	endfunction

	function automatic longint pick_radius();
		case ($urandom_range(3))
			0: return 8;
			1: return 1000;
			2: return 65536;
			default: return 1 << 28;
		endcase
	endfunction

	task automatic clear_table(input bit last);
		send_item(OP_CLEAR, rand_coord(), rand_coord(), last);
		box_x.delete();
		box_y.delete();
		box_r.delete();
	endtask

	// ring in a random box; a few vertices land anywhere
	task automatic load_ring(input int unsigned count, input bit close);
		longint cx, cy, r;
		int unsigned k;
		r = pick_radius();
		cx = rand_offset(1 << 30);
		cy = rand_offset(1 << 30);
		box_x.push_back(cx);
		box_y.push_back(cy);
		box_r.push_back(r);
		for (k = 0; k < count; k++) begin
			if ($urandom_range(19) == 0)
				send_item(OP_LOAD, rand_coord(), rand_coord(), close && k == count - 1);
			else
				send_item(OP_LOAD, cx + rand_offset(r), cy + rand_offset(r),
					close && k == count - 1);
		end
	endtask

	// query aimed into a known box, onto a stored vertex, or anywhere
	task automatic send_query(input bit last);
		int unsigned roll, b;
		roll = $urandom_range(99);
		if (box_x.size() == 0 || roll < 20) begin
			send_item(OP_QUERY, rand_coord(), rand_coord(), last);
		end else if (roll < 32 && stored_vertices > 0) begin
			b = $urandom_range(stored_vertices - 1);
			send_item(OP_QUERY, ring_vx[b], ring_vy[b], last);
		end else begin
			b = $urandom_range(box_x.size() - 1);
			send_item(OP_QUERY, box_x[b] + rand_offset(box_r[b]),
				box_y[b] + rand_offset(box_r[b]), last);
		end
	endtask

	// extremes, every operation and the simple special cases
	task automatic test_directed();
		send_item(OP_QUERY, 0, 0, 1'b0);                  // no zones yet
		send_item(OP_NOP, C_MIN, C_MAX, 1'b1);
		send_item(OP_LOAD, C_MIN, C_MIN, 1'b0);           // ring over the whole plane
		send_item(OP_LOAD, C_MAX, C_MIN, 1'b0);
		send_item(OP_LOAD, C_MAX, C_MAX, 1'b0);
		send_item(OP_LOAD, C_MIN, C_MAX, 1'b1);
		send_item(OP_QUERY, 0, 0, 1'b0);
		send_item(OP_QUERY, C_MAX, 0, 1'b0);
		send_item(OP_QUERY, C_MIN, C_MIN, 1'b0);
		send_item(OP_LOAD, 5, 5, 1'b0);                   // two-vertex ring is refused
		send_item(OP_LOAD, 6, 6, 1'b1);
		send_item(OP_LOAD, 1, 1, 1'b1);                   // one-vertex ring too
		send_item(OP_LOAD, 100, 100, 1'b0);               // ring left open
		send_item(OP_QUERY, 150, 150, 1'b1);              // ends the batch
		send_item(OP_LOAD, 200, 100, 1'b0);
		send_item(OP_LOAD, 150, 300, 1'b1);
		send_item(OP_QUERY, 150, 150, 1'b0);              // first ring still wins
		send_item(OP_QUERY, C_MAX, C_MAX, 1'b0);
		send_item(OP_QUERY, -1, C_MIN + 1, 1'b0);
		send_item(OP_CLEAR, C_MAX, C_MIN, 1'b1);          // count survives a clear
		send_item(OP_QUERY, 150, 150, 1'b1);
		send_item(OP_NOP, 0, 0, 1'b0);
		wait_for_answers();
	endtask

	// zone table full, then an open ring queried and closed against the full table
	task automatic test_capacity_limits();
		int unsigned k;
		clear_table(1'b0);
		for (k = 0; k < ZONE_CAP; k++)
			load_ring(3, 1'b1);
		load_ring(3, 1'b1);
		load_ring(2, 1'b0);
		send_query(1'b0);
		send_query(1'b1);
		send_item(OP_LOAD, rand_coord(), rand_coord(), 1'b1);
		send_query(1'b0);
		clear_table(1'b0);
		wait_for_answers();
	endtask

	// receiver holds off while items keep coming, so the input stalls
	task automatic test_output_stall();
		int unsigned k;
		load_ring(5, 1'b1);
		load_ring(4, 1'b1);
		wait_for_answers();
		ready_hold_cycles = 400;
		for (k = 0; k < 14; k++) begin
			if (k % 5 == 4)
				send_item(OP_NOP, rand_coord(), rand_coord(), 1'b0);
			else
				send_query(k == 13);
		end
		wait_for_answers();
		clear_table(1'b0);
	endtask

	// random rings and queries with some noise and broken rings
	task automatic test_random_traffic();
		int unsigned start, done, roll;
		start = items_sent;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			// one stretch without idle cycles on either side
			if (done >= 200 && done < 320) begin
				send_idle_pct = 0;
				take_idle_pct = 0;
			end else begin
				send_idle_pct = 24;
				take_idle_pct = 24;
			end
			roll = $urandom_range(99);
			if (stored_vertices > 96 || ring_count >= 14)
				clear_table(1'($urandom_range(1)));
			else if (roll < 38)
				load_ring($urandom_range(9) == 0 ? 12 : $urandom_range(3, 8), 1'b1);
			else if (roll < 76)
				send_query($urandom_range(5) == 0);
			else if (roll < 84)
				load_ring($urandom_range(1, 2), 1'b1);
			else if (roll < 89)
				load_ring($urandom_range(1, 4), 1'b0);
			else if (roll < 95)
				send_item(OP_NOP, rand_coord(), rand_coord(), 1'($urandom_range(1)));
			else
				clear_table(1'($urandom_range(1)));
			done = items_sent - start;
		end
		send_idle_pct = 24;
		take_idle_pct = 24;
		wait_for_answers();
	endtask

	// receiver side of the output stream
	initial begin
		forever begin
			@(negedge clk);
			if (ready_hold_cycles > 0) begin
				m_tready = 1'b0;
				ready_hold_cycles--;
			end else begin
				m_tready = ($urandom_range(99) >= take_idle_pct);
			end
		end
	end

	// compare every returned item with the oldest expected answer
	zone_answer_t oldest_answer;
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected item", m_tdata, '0);
			end else begin
				oldest_answer = pending_answers.pop_front();
				if (m_tdata[ZONE_W-1:0] !== oldest_answer.zone)
					report_mismatch("zone", m_tdata[ZONE_W-1:0], oldest_answer.zone);
				if (m_tdata[ZONE_W +: CNT_W] !== oldest_answer.matched)
					report_mismatch("matched_total", m_tdata[ZONE_W +: CNT_W],
						oldest_answer.matched);
				if (m_tuser !== oldest_answer.status)
					report_mismatch("status", m_tuser, oldest_answer.status);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
				pending_answers.size());
			$display("[point_zone_assigner_unit] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_capacity_limits();
		test_output_stall();
		test_random_traffic();
		repeat (100) @(posedge clk);
		$display("ran %0d items: %0d queries, %0d inside a zone", items_sent, query_count,
			hit_count);
		$display("rings kept %0d, refused %0d, including a full zone table",
			rings_kept, rings_refused);
		if (mismatch_count == 0 && pending_answers.size() == 0) begin
			$display("[point_zone_assigner_unit] OK");
		end else begin
			$display("%0d mismatches, %0d answers outstanding", mismatch_count,
				pending_answers.size());
			$display("[point_zone_assigner_unit] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== point_zone_assigner_unit.f =====
sv/pza_pkg.sv
sv/pza_vertex_store.sv
sv/pza_edge_unit.sv
sv/point_zone_assigner_unit.sv
test/point_zone_assigner_unit_test.sv
